// ----- design/rv32se_pkg.sv -----
`default_nettype none

package rv32se_pkg;

   // Architectural sizes
   localparam int XLEN     = 32;
   localparam int NUM_REGS = 32;
   localparam int REG_AW   = 5;

   // Major opcodes
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [6:0] OP_ZERO   = 7'h00;

   // funct7 values for register-register ops
   localparam logic [6:0] F7_ADD = 7'h00;
   localparam logic [6:0] F7_SUB = 7'h20;

   // funct3 values
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_LB   = 3'd0;
   localparam logic [2:0] F3_LH   = 3'd1;
   localparam logic [2:0] F3_LW   = 3'd2;
   localparam logic [2:0] F3_LBU  = 3'd4;
   localparam logic [2:0] F3_LHU  = 3'd5;
   localparam logic [2:0] F3_SB   = 3'd0;
   localparam logic [2:0] F3_SH   = 3'd1;
   localparam logic [2:0] F3_SW   = 3'd2;

   // Upper-immediate mask
   localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

   // Request item kinds
   localparam logic FUNC_EXEC      = 1'b0;
   localparam logic FUNC_LOAD_DATA = 1'b1;

   // Memory request codes
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNIMP = 2'd1;
   localparam logic [1:0] ST_ORDER = 2'd2;

   // Register file write port
   typedef struct packed {
      logic              we;
      logic [REG_AW-1:0] addr;
      logic [XLEN-1:0]   data;
   } rf_wr_type;

   // Register file read request
   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] rs1;
      logic [REG_AW-1:0] rs2;
   } rf_rd_type;

endpackage

`default_nettype wire

// ----- design/rv32se_ram.sv -----
`default_nettype none

module rv32se_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port (read-before-write)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/rv32se_regfile.sv -----
`default_nettype none

module rv32se_regfile (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rv32se_pkg::rf_rd_type   rd_req,
   input  wire rv32se_pkg::rf_wr_type   wr_req,
   output logic [rv32se_pkg::XLEN-1:0]  rs1_data,
   output logic [rv32se_pkg::XLEN-1:0]  rs2_data
);

   logic [rv32se_pkg::XLEN-1:0]     ram1_q;
   logic [rv32se_pkg::XLEN-1:0]     ram2_q;
   logic [rv32se_pkg::NUM_REGS-1:0] valid_ff;
   logic                            v1_ff;
   logic                            v2_ff;
   logic [rv32se_pkg::REG_AW-1:0]   a1_ff;
   logic [rv32se_pkg::REG_AW-1:0]   a2_ff;
   rv32se_pkg::rf_wr_type           fwd_ff;
   logic                            wr_ok;

   // x0 is never stored
   assign wr_ok = wr_req.we && (wr_req.addr != '0);

   // Two copies give two read ports
   rv32se_ram #(
      .WIDTH(rv32se_pkg::XLEN),
      .DEPTH(rv32se_pkg::NUM_REGS)
   ) u_ram1 (
      .clock  (clock),
      .wr_en  (wr_ok),
      .wr_addr(wr_req.addr),
      .wr_data(wr_req.data),
      .rd_en  (rd_req.en),
      .rd_addr(rd_req.rs1),
      .rd_data(ram1_q)
   );

   rv32se_ram #(
      .WIDTH(rv32se_pkg::XLEN),
      .DEPTH(rv32se_pkg::NUM_REGS)
   ) u_ram2 (
      .clock  (clock),
      .wr_en  (wr_ok),
      .wr_addr(wr_req.addr),
      .wr_data(wr_req.data),
      .rd_en  (rd_req.en),
      .rd_addr(rd_req.rs2),
      .rd_data(ram2_q)
   );

   // Written-since-reset bits; an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ok) begin
         valid_ff[wr_req.addr] <= 1'b1;
      end
   end

   // Read-side tags, sampled with the RAM read
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (rd_req.en) begin
         v1_ff <= valid_ff[rd_req.rs1];
         v2_ff <= valid_ff[rd_req.rs2];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         a1_ff <= rd_req.rs1;
         a2_ff <= rd_req.rs2;
      end
   end

   // Most recent write, to cover a write landing on the read edge
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff.we <= 1'b0;
      end else if (wr_ok) begin
         fwd_ff.we <= 1'b1;
      end
      if (wr_ok) begin
         fwd_ff.addr <= wr_req.addr;
         fwd_ff.data <= wr_req.data;
      end
   end

   // Resolve read data
   always_comb begin
      if (fwd_ff.we && (fwd_ff.addr == a1_ff)) begin
         rs1_data = fwd_ff.data;
      end else if (v1_ff) begin
         rs1_data = ram1_q;
      end else begin
         rs1_data = '0;
      end
      if (fwd_ff.we && (fwd_ff.addr == a2_ff)) begin
         rs2_data = fwd_ff.data;
      end else if (v2_ff) begin
         rs2_data = ram2_q;
      end else begin
         rs2_data = '0;
      end
   end

`ifndef NO_ASSERTIONS
   // x0 never becomes valid
   a_x0_never_valid: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0])
      else $error("x0 marked as written");

   // A write marks its entry valid on the next cycle
   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_ok |=> valid_ff[$past(wr_req.addr)])
      else $error("write did not set valid bit");

   // Forwarded entry is never x0
   a_fwd_not_x0: assert property (@(posedge clock) disable iff (reset)
      fwd_ff.we |-> (fwd_ff.addr != '0))
      else $error("forward register holds x0");
`endif

endmodule

`default_nettype wire

// ----- design/rv32se_exec.sv -----
`default_nettype none

module rv32se_exec (
   input  wire logic [31:0] instr,
   input  wire logic        func,
   input  wire logic [31:0] load_value,
   input  wire logic [31:0] pc,
   input  wire logic [31:0] rs1_val,
   input  wire logic [31:0] rs2_val,
   input  wire logic        ld_pend,
   input  wire logic [4:0]  ld_dest,
   input  wire logic [2:0]  ld_kind,
   output logic [31:0]      next_pc,
   output logic [1:0]       mem_request,
   output logic [31:0]      mem_address,
   output logic [1:0]       mem_size,
   output logic [31:0]      store_value,
   output logic             halted,
   output logic [1:0]       status,
   output logic             ld_pend_nx,
   output logic [4:0]       ld_dest_nx,
   output logic [2:0]       ld_kind_nx,
   output rv32se_pkg::rf_wr_type wr
);

   logic [6:0]  opcode;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic [31:0] pc_plus4;
   logic [31:0] rs1_imm;
   logic        eq;
   logic [31:0] ld_ext;

   // Field decode and immediates
   assign opcode   = instr[6:0];
   assign rd       = instr[11:7];
   assign f3       = instr[14:12];
   assign f7       = instr[31:25];
   assign imm_i    = {{20{instr[31]}}, instr[31:20]};
   assign imm_s    = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b    = {{20{instr[31]}}, instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_j    = {{12{instr[31]}}, instr[19:12], instr[20], instr[30:21], 1'b0};
   assign pc_plus4 = pc + 32'd4;
   assign rs1_imm  = rs1_val + imm_i;
   assign eq       = (rs1_val == rs2_val);

   // Load data extension
   always_comb begin
      unique case (ld_kind)
         rv32se_pkg::F3_LB:  ld_ext = {{24{load_value[7]}}, load_value[7:0]};
         rv32se_pkg::F3_LH:  ld_ext = {{16{load_value[15]}}, load_value[15:0]};
         rv32se_pkg::F3_LBU: ld_ext = {24'd0, load_value[7:0]};
         rv32se_pkg::F3_LHU: ld_ext = {16'd0, load_value[15:0]};
         default:            ld_ext = load_value;
      endcase
   end

   // Execute one request
   always_comb begin
      next_pc     = pc;
      mem_request = rv32se_pkg::MEM_NONE;
      mem_address = '0;
      mem_size    = '0;
      store_value = '0;
      halted      = 1'b0;
      status      = rv32se_pkg::ST_OK;
      ld_pend_nx  = ld_pend;
      ld_dest_nx  = ld_dest;
      ld_kind_nx  = ld_kind;
      wr          = '0;
      wr.addr     = rd;

      if (func == rv32se_pkg::FUNC_LOAD_DATA) begin
         if (!ld_pend) begin
            status = rv32se_pkg::ST_ORDER;
         end else begin
            wr.we      = 1'b1;
            wr.addr    = ld_dest;
            wr.data    = ld_ext;
            ld_pend_nx = 1'b0;
         end
      end else if (ld_pend) begin
         status = rv32se_pkg::ST_ORDER;
      end else begin
         next_pc = pc_plus4;
         unique case (opcode)
            rv32se_pkg::OP_IMM: begin
               if (f3 == rv32se_pkg::F3_ADD) begin
                  wr.we   = 1'b1;
                  wr.data = rs1_imm;
               end else begin
                  status = rv32se_pkg::ST_UNIMP;
               end
            end
            rv32se_pkg::OP_REG: begin
               if (f3 == rv32se_pkg::F3_ADD && f7 == rv32se_pkg::F7_ADD) begin
                  wr.we   = 1'b1;
                  wr.data = rs1_val + rs2_val;
               end else if (f3 == rv32se_pkg::F3_ADD && f7 == rv32se_pkg::F7_SUB) begin
                  wr.we   = 1'b1;
                  wr.data = rs1_val - rs2_val;
               end else begin
                  status = rv32se_pkg::ST_UNIMP;
               end
            end
            rv32se_pkg::OP_LUI: begin
               wr.we   = 1'b1;
               wr.data = instr & rv32se_pkg::UPPER_MASK;
            end
            rv32se_pkg::OP_AUIPC: begin
               wr.we   = 1'b1;
               wr.data = pc + (instr & rv32se_pkg::UPPER_MASK);
            end
            rv32se_pkg::OP_JAL: begin
               wr.we   = 1'b1;
               wr.data = pc_plus4;
               next_pc = pc + imm_j;
            end
            rv32se_pkg::OP_JALR: begin
               wr.we   = 1'b1;
               wr.data = pc_plus4;
               next_pc = {rs1_imm[31:1], 1'b0};
            end
            rv32se_pkg::OP_BRANCH: begin
               if (f3 == rv32se_pkg::F3_BEQ) begin
                  if (eq) next_pc = pc + imm_b;
               end else if (f3 == rv32se_pkg::F3_BNE) begin
                  if (!eq) next_pc = pc + imm_b;
               end else begin
                  status = rv32se_pkg::ST_UNIMP;
               end
            end
            rv32se_pkg::OP_LOAD: begin
               if (f3 == rv32se_pkg::F3_LB || f3 == rv32se_pkg::F3_LH ||
                   f3 == rv32se_pkg::F3_LW || f3 == rv32se_pkg::F3_LBU ||
                   f3 == rv32se_pkg::F3_LHU) begin
                  mem_request = rv32se_pkg::MEM_LOAD;
                  mem_address = rs1_imm;
                  mem_size    = f3[1:0];
                  ld_pend_nx  = 1'b1;
                  ld_dest_nx  = rd;
                  ld_kind_nx  = f3;
               end else begin
                  status = rv32se_pkg::ST_UNIMP;
               end
            end
            rv32se_pkg::OP_STORE: begin
               if (f3 == rv32se_pkg::F3_SB || f3 == rv32se_pkg::F3_SH ||
                   f3 == rv32se_pkg::F3_SW) begin
                  mem_request = rv32se_pkg::MEM_STORE;
                  mem_address = rs1_val + imm_s;
                  mem_size    = f3[1:0];
                  if (f3 == rv32se_pkg::F3_SB) begin
                     store_value = {24'd0, rs2_val[7:0]};
                  end else if (f3 == rv32se_pkg::F3_SH) begin
                     store_value = {16'd0, rs2_val[15:0]};
                  end else begin
                     store_value = rs2_val;
                  end
               end else begin
                  status = rv32se_pkg::ST_UNIMP;
               end
            end
            rv32se_pkg::OP_SYSTEM, rv32se_pkg::OP_ZERO: begin
               halted  = 1'b1;
               next_pc = '0;
            end
            default: begin
               status = rv32se_pkg::ST_UNIMP;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- design/rv32i_subset_execute_top.sv -----
`default_nettype none

// Response path: the register file is read when a request is accepted, then execute feeds the
// response register, from which the response leaves once rsp_tready is high.
// Throughput: one request per cycle while rsp_tready stays high; the register file read in
// RAM overlaps the previous request's execute, with the latest write forwarded around the RAM.
// Reset (synchronous, active high): pc, pending-load state, register valid bits and
// pipeline/output valids cleared; req_tready low; all registers read as zero until written.

module rv32i_subset_execute_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,  // instruction[31:0], load_value[63:32]
   input  wire logic         req_tuser,  // func
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata   // next_pc[31:0], mem_request[33:32],
                                          // mem_address[65:34], mem_size[67:66],
                                          // store_value[99:68], halted[100],
                                          // status[102:101], zero[103]
);

   logic                  s1_v_ff;
   logic                  s1_func_ff;
   logic [31:0]           s1_instr_ff;
   logic [31:0]           s1_load_ff;
   logic [31:0]           pc_ff;
   logic                  ld_pend_ff;
   logic [4:0]            ld_dest_ff;
   logic [2:0]            ld_kind_ff;
   logic                  rsp_v_ff;
   logic [103:0]          rsp_data_ff;
   logic                  req_fire;
   logic                  s1_go;
   rv32se_pkg::rf_rd_type rd_req;
   rv32se_pkg::rf_wr_type ex_wr;
   rv32se_pkg::rf_wr_type wr_req;
   logic [31:0]           rs1_val;
   logic [31:0]           rs2_val;
   logic [31:0]           next_pc;
   logic [1:0]            mem_request;
   logic [31:0]           mem_address;
   logic [1:0]            mem_size;
   logic [31:0]           store_value;
   logic                  halted;
   logic [1:0]            status;
   logic                  ld_pend_in;
   logic [4:0]            ld_dest_in;
   logic [2:0]            ld_kind_in;

   // Handshake
   assign s1_go      = s1_v_ff && (!rsp_v_ff || rsp_tready);
   assign req_tready = !reset && (!s1_v_ff || s1_go);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Register reads issued on accept
   assign rd_req.en  = req_fire;
   assign rd_req.rs1 = req_tdata[19:15];
   assign rd_req.rs2 = req_tdata[24:20];

   // Write back only when the execute stage retires
   always_comb begin
      wr_req    = ex_wr;
      wr_req.we = ex_wr.we && s1_go;
   end

   rv32se_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .wr_req  (wr_req),
      .rs1_data(rs1_val),
      .rs2_data(rs2_val)
   );

   rv32se_exec u_exec (
      .instr      (s1_instr_ff),
      .func       (s1_func_ff),
      .load_value (s1_load_ff),
      .pc         (pc_ff),
      .rs1_val    (rs1_val),
      .rs2_val    (rs2_val),
      .ld_pend    (ld_pend_ff),
      .ld_dest    (ld_dest_ff),
      .ld_kind    (ld_kind_ff),
      .next_pc    (next_pc),
      .mem_request(mem_request),
      .mem_address(mem_address),
      .mem_size   (mem_size),
      .store_value(store_value),
      .halted     (halted),
      .status     (status),
      .ld_pend_nx (ld_pend_in),
      .ld_dest_nx (ld_dest_in),
      .ld_kind_nx (ld_kind_in),
      .wr         (ex_wr)
   );

   // Execute stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (req_tready) begin
         s1_v_ff <= req_tvalid;
      end
   end

   // Execute stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff  <= req_tuser;
         s1_instr_ff <= req_tdata[31:0];
         s1_load_ff  <= req_tdata[63:32];
      end
   end

   // Architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= '0;
         ld_pend_ff <= 1'b0;
         ld_dest_ff <= '0;
         ld_kind_ff <= '0;
      end else if (s1_go) begin
         pc_ff      <= next_pc;
         ld_pend_ff <= ld_pend_in;
         ld_dest_ff <= ld_dest_in;
         ld_kind_ff <= ld_kind_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff <= {1'b0, status, halted, store_value, mem_size,
                         mem_address, mem_request, next_pc};
      end
   end

`ifndef NO_ASSERTIONS
   // A retired load request leaves a load pending
   a_load_sets_pending: assert property (@(posedge clock) disable iff (reset)
      s1_go && (mem_request == rv32se_pkg::MEM_LOAD) |=> ld_pend_ff)
      else $error("load request did not set pending");

   // An ignored request keeps the pc
   a_order_keeps_pc: assert property (@(posedge clock) disable iff (reset)
      s1_go && (status == rv32se_pkg::ST_ORDER) |=> (pc_ff == $past(pc_ff)))
      else $error("out-of-order request moved the pc");

   // Halt responses carry pc zero
   a_halt_pc_zero: assert property (@(posedge clock) disable iff (reset)
      s1_go && halted |=> (pc_ff == '0) && (rsp_tdata[31:0] == '0))
      else $error("halt did not clear the pc");

   // Stalled execute stage keeps its request
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s1_go |=> s1_v_ff && $stable(s1_instr_ff) && $stable(pc_ff))
      else $error("execute stage changed while stalled");
`endif

endmodule

`default_nettype wire

// ----- bench/rv32i_subset_execute_top_test.sv -----
`timescale 1ns / 100ps

module rv32i_subset_execute_top_test;
   import rv32se_pkg::*;

   // Encodings outside the implemented subset
   localparam logic [6:0] OP_UNKNOWN  = 7'h7F;
   localparam logic [2:0] F3_RESERVED = 3'd7;
   localparam logic [6:0] F7_OTHER    = 7'h01;

   // One response, laid out as on rsp_tdata (next_pc in the low bits)
   typedef struct packed {
      logic        pad;
      logic [1:0]  status;
      logic        halted;
      logic [31:0] store_value;
      logic [1:0]  mem_size;
      logic [31:0] mem_address;
      logic [1:0]  mem_request;
      logic [31:0] next_pc;
   } exec_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;   // instruction[31:0], load_value[63:32]
   logic         req_tuser = 1'b0; // func
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;        // next_pc, mem_request, mem_address, mem_size,
                                   // store_value, halted, status, zero pad

   // Architectural state tracked alongside the core
   logic [31:0]  arch_pc = '0;
   logic [31:0]  arch_regs [32];
   logic         load_busy = 1'b0;
   logic [4:0]   load_rd = '0;
   logic [2:0]   load_f3 = '0;

   exec_result_type pending_results [$];
   exec_result_type rsp_seen, rsp_want;
   bit           idle_on = 1'b1;
   bit           sink_stalls = 1'b1;
   int           sink_hold = 0;
   int           mismatches = 0;
   int           requests_sent = 0;
   int           results_checked = 0;
   int           loads_seen = 0, stores_seen = 0, halts_seen = 0;
   int           unimp_seen = 0, order_seen = 0;

   rv32i_subset_execute_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Instruction encoders
   function automatic logic [31:0] enc_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                         logic [4:0] rs1, logic [11:0] imm);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                         logic [4:0] rs1, logic [4:0] rs2);
      return {f7, rs2, rs1, f3, rd, OP_REG};
   endfunction

   function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                         logic [11:0] imm);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
   endfunction

   function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                         logic [12:0] imm);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
   endfunction

   function automatic logic [31:0] enc_u(logic [6:0] op, logic [4:0] rd, logic [19:0] imm);
      return {imm, rd, op};
   endfunction

   function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
   endfunction

   function automatic void write_reg(logic [4:0] idx, logic [31:0] value);
      if (idx != 5'd0) begin
         arch_regs[idx] = value;
      end
   endfunction

   // Executes one request against the tracked state and returns the response it causes
   function automatic exec_result_type predict_execute(logic fn, logic [31:0] w,
                                                       logic [31:0] ldv);
      exec_result_type r;
      logic [4:0]   rd;
      logic [2:0]   f3;
      logic [31:0]  src1, src2, imm_i, imm_s, imm_b, imm_j, nxt, v;
      r = '0;
      rd = w[11:7];
      f3 = w[14:12];
      src1 = arch_regs[w[19:15]];
      src2 = arch_regs[w[24:20]];
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      nxt = arch_pc + 32'd4;
      if (fn == FUNC_LOAD_DATA) begin
         if (!load_busy) begin
            r.status = ST_ORDER;
         end else begin
            case (load_f3)
               F3_LB:   v = {{24{ldv[7]}}, ldv[7:0]};
               F3_LH:   v = {{16{ldv[15]}}, ldv[15:0]};
               F3_LBU:  v = {24'h0, ldv[7:0]};
               F3_LHU:  v = {16'h0, ldv[15:0]};
               default: v = ldv;
            endcase
            write_reg(load_rd, v);
            load_busy = 1'b0;
         end
      end else if (load_busy) begin
         r.status = ST_ORDER;
      end else begin
         case (w[6:0])
            OP_IMM: begin
               if (f3 == F3_ADD) write_reg(rd, src1 + imm_i);
               else r.status = ST_UNIMP;
            end
            OP_REG: begin
               if (f3 == F3_ADD && w[31:25] == F7_ADD) write_reg(rd, src1 + src2);
               else if (f3 == F3_ADD && w[31:25] == F7_SUB) write_reg(rd, src1 - src2);
               else r.status = ST_UNIMP;
            end
            OP_LUI:   write_reg(rd, w & UPPER_MASK);
            OP_AUIPC: write_reg(rd, arch_pc + (w & UPPER_MASK));
            OP_JAL: begin
               write_reg(rd, nxt);
               nxt = arch_pc + imm_j;
            end
            OP_JALR: begin
               v = (src1 + imm_i) & ~32'd1;
               write_reg(rd, nxt);
               nxt = v;
            end
            OP_BRANCH: begin
               if (f3 == F3_BEQ) begin
                  if (src1 == src2) nxt = arch_pc + imm_b;
               end else if (f3 == F3_BNE) begin
                  if (src1 != src2) nxt = arch_pc + imm_b;
               end else begin
                  r.status = ST_UNIMP;
               end
            end
            OP_LOAD: begin
               case (f3)
                  F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU: begin
                     r.mem_request = MEM_LOAD;
                     r.mem_address = src1 + imm_i;
                     r.mem_size = f3[1:0];
                     load_busy = 1'b1;
                     load_rd = rd;
                     load_f3 = f3;
                  end
                  default: r.status = ST_UNIMP;
               endcase
            end
            OP_STORE: begin
               if (f3 <= F3_SW) begin
                  r.mem_request = MEM_STORE;
                  r.mem_address = src1 + imm_s;
                  r.mem_size = f3[1:0];
                  case (f3)
                     F3_SB:   r.store_value = {24'h0, src2[7:0]};
                     F3_SH:   r.store_value = {16'h0, src2[15:0]};
                     default: r.store_value = src2;
                  endcase
               end else begin
                  r.status = ST_UNIMP;
               end
            end
            OP_SYSTEM, OP_ZERO: begin
               r.halted = 1'b1;
               nxt = '0;
            end
            default: r.status = ST_UNIMP;
         endcase
         arch_pc = nxt;
      end
      r.next_pc = arch_pc;
      return r;
   endfunction

   // Mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 3);
      else if (r < 92) n = $urandom_range(4, 8);
      else n = $urandom_range(12, 40);
      return n;
   endfunction

   // Random instruction, weighted toward the implemented subset
   function automatic logic [31:0] random_instruction();
      logic [31:0] w;
      int          pick;
      w = $urandom;
      pick = $urandom_range(0, 99);
      // low register numbers half the time so results feed later instructions
      if ($urandom_range(0, 1)) begin
         w[11:7] = 5'($urandom_range(0, 7));
         w[19:15] = 5'($urandom_range(0, 7));
         w[24:20] = 5'($urandom_range(0, 7));
      end
      if (pick < 12) begin
         w[6:0] = OP_IMM;
         w[14:12] = F3_ADD;
      end else if (pick < 22) begin
         w[6:0] = OP_REG;
         w[14:12] = F3_ADD;
         w[31:25] = $urandom_range(0, 1) ? F7_SUB : F7_ADD;
      end else if (pick < 27) begin
         w[6:0] = OP_LUI;
      end else if (pick < 32) begin
         w[6:0] = OP_AUIPC;
      end else if (pick < 37) begin
         w[6:0] = OP_JAL;
      end else if (pick < 42) begin
         w[6:0] = OP_JALR;
      end else if (pick < 54) begin
         w[6:0] = OP_BRANCH;
         w[14:12] = $urandom_range(0, 1) ? F3_BNE : F3_BEQ;
      end else if (pick < 70) begin
         w[6:0] = OP_LOAD;
         case ($urandom_range(0, 4))
            0:       w[14:12] = F3_LB;
            1:       w[14:12] = F3_LH;
            2:       w[14:12] = F3_LW;
            3:       w[14:12] = F3_LBU;
            default: w[14:12] = F3_LHU;
         endcase
      end else if (pick < 82) begin
         w[6:0] = OP_STORE;
         w[14:12] = 3'($urandom_range(F3_SB, F3_SW));
      end else if (pick < 85) begin
         w[6:0] = $urandom_range(0, 1) ? OP_SYSTEM : OP_ZERO;
      end else if (pick < 93) begin
         // known opcode, funct3/funct7 outside the subset
         case ($urandom_range(0, 4))
            0: begin
               w[6:0] = OP_IMM;
               w[14:12] = 3'($urandom_range(1, 7));
            end
            1: begin
               w[6:0] = OP_REG;
               w[31:25] = w[31:25] | F7_OTHER;
            end
            2: begin
               w[6:0] = OP_BRANCH;
               w[14:12] = 3'($urandom_range(2, 7));
            end
            3: begin
               w[6:0] = OP_LOAD;
               case ($urandom_range(0, 2))
                  0:       w[14:12] = F3_LW + 3'd1;
                  1:       w[14:12] = F3_LHU + 3'd1;
                  default: w[14:12] = F3_RESERVED;
               endcase
            end
            default: begin
               w[6:0] = OP_STORE;
               w[14:12] = 3'($urandom_range(3, 7));
            end
         endcase
      end
      // anything left keeps the fully random word
      return w;
   endfunction

   // Drives one request; returns at the rising edge that accepts it
   task automatic send_request(input logic fn, input logic [31:0] word,
                               input logic [31:0] ldv);
      int gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ldv, word};
      req_tuser <= fn;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_execute(fn, word, ldv));
      requests_sent++;
   endtask

   task automatic exec_instr(input logic [31:0] word);
      send_request(FUNC_EXEC, word, $urandom);
   endtask

   task automatic deliver_data(input logic [31:0] ldv);
      send_request(FUNC_LOAD_DATA, $urandom, ldv);
   endtask

   // Hold off new requests until every outstanding response is back
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic test_alu();
      exec_instr(enc_i(OP_IMM, F3_ADD, 5'd1, 5'd0, 12'hFFF));  // x1 = -1
      exec_instr(enc_i(OP_IMM, F3_ADD, 5'd2, 5'd0, 12'h7FF));  // x2 = 2047
      exec_instr(enc_r(F7_ADD, F3_ADD, 5'd3, 5'd1, 5'd2));     // wraps
      exec_instr(enc_r(F7_SUB, F3_ADD, 5'd4, 5'd0, 5'd1));
      exec_instr(enc_i(OP_IMM, F3_ADD, 5'd0, 5'd1, 12'h005));  // x0 stays zero
   endtask

   task automatic test_upper_imm();
      exec_instr(enc_u(OP_LUI, 5'd5, 20'hFFFFF));
      exec_instr(enc_u(OP_AUIPC, 5'd6, 20'h80000));
   endtask

   task automatic test_jumps();
      exec_instr(enc_j(5'd7, 21'h000802));                      // misaligned target
      exec_instr(enc_j(5'd0, 21'h100000));                      // most negative offset
      exec_instr(enc_i(OP_JALR, F3_RESERVED, 5'd8, 5'd2, 12'h000)); // funct3 ignored, bit 0 cleared
   endtask

   task automatic test_branches();
      exec_instr(enc_b(F3_BEQ, 5'd0, 5'd0, 13'h1000));          // taken, most negative
      exec_instr(enc_b(F3_BNE, 5'd1, 5'd1, 13'h0FFE));          // not taken
   endtask

   task automatic test_loads();
      exec_instr(enc_i(OP_LOAD, F3_LB, 5'd9, 5'd0, 12'hFFF));
      deliver_data(32'h0000_0080);                              // sign-extended byte
      exec_instr(enc_i(OP_LOAD, F3_LHU, 5'd10, 5'd1, 12'h7FF));
      deliver_data(32'hFFFF_8000);                              // upper bits dropped
      exec_instr(enc_i(OP_LOAD, F3_LW, 5'd0, 5'd2, 12'h000));   // load into x0
      exec_instr(enc_i(OP_IMM, F3_ADD, 5'd11, 5'd0, 12'h001));  // instruction while load pending
      deliver_data(32'hDEAD_BEEF);
      deliver_data(32'hFFFF_FFFF);                              // data with nothing pending
   endtask

   task automatic test_stores();
      exec_instr(enc_s(F3_SB, 5'd1, 5'd9, 12'h800));
      exec_instr(enc_s(F3_SW, 5'd0, 5'd1, 12'h7FF));
   endtask

   task automatic test_halt();
      exec_instr(enc_i(OP_SYSTEM, 3'd0, 5'd0, 5'd0, 12'h000));
      exec_instr(32'hFFFF_FF80);                                // opcode field zero
   endtask

   task automatic test_unimplemented();
      exec_instr(enc_i(OP_UNKNOWN, F3_ADD, 5'd12, 5'd1, 12'h123));
      exec_instr(enc_i(OP_IMM, F3_RESERVED, 5'd12, 5'd1, 12'h001));
      exec_instr(enc_r(F7_OTHER, F3_ADD, 5'd12, 5'd1, 5'd2));
   endtask

   // Random programs: loads mostly followed by their data, with some disorder mixed in
   task automatic test_random_program(input int count);
      for (int i = 0; i < count; i++) begin
         exec_instr(random_instruction());
         if (load_busy) begin
            if ($urandom_range(0, 9) == 0) exec_instr(random_instruction());
            deliver_data($urandom);
         end else if ($urandom_range(0, 24) == 0) begin
            deliver_data($urandom);
         end
      end
   endtask

   // Response-side backpressure
   always @(negedge clock) begin
      if (sink_hold != 0) begin
         sink_hold = sink_hold - 1;
         rsp_tready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
         sink_hold = idle_length() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   // Check each accepted response against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen = rsp_tdata;
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            mismatches++;
         end else begin
            rsp_want = pending_results.pop_front();
            compare_field("next_pc", rsp_want.next_pc, rsp_seen.next_pc);
            compare_field("mem_request", rsp_want.mem_request, rsp_seen.mem_request);
            compare_field("mem_address", rsp_want.mem_address, rsp_seen.mem_address);
            compare_field("mem_size", rsp_want.mem_size, rsp_seen.mem_size);
            compare_field("store_value", rsp_want.store_value, rsp_seen.store_value);
            compare_field("halted", rsp_want.halted, rsp_seen.halted);
            compare_field("status", rsp_want.status, rsp_seen.status);
            compare_field("pad", rsp_want.pad, rsp_seen.pad);
            results_checked++;
            if (rsp_want.mem_request == MEM_LOAD) loads_seen++;
            if (rsp_want.mem_request == MEM_STORE) stores_seen++;
            if (rsp_want.halted) halts_seen++;
            if (rsp_want.status == ST_UNIMP) unimp_seen++;
            if (rsp_want.status == ST_ORDER) order_seen++;
         end
      end
   end

   initial begin
      foreach (arch_regs[i]) arch_regs[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_alu();
      test_upper_imm();
      test_jumps();
      test_branches();
      test_loads();
      test_stores();
      test_halt();
      test_unimplemented();
      wait_for_drain();

      // random segments under different idle and backpressure mixes
      test_random_program(60);
      idle_on = 1'b0;
      sink_stalls = 1'b0;
      test_random_program(60);
      idle_on = 1'b1;
      test_random_program(60);
      wait_for_drain();
      idle_on = 1'b0;
      sink_stalls = 1'b1;
      test_random_program(60);
      idle_on = 1'b1;
      test_random_program(60);

      wait_for_drain();
      repeat (8) @(posedge clock);
      $display("Covered %0d requests, %0d responses: %0d loads, %0d stores, %0d halts,",
               requests_sent, results_checked, loads_seen, stores_seen, halts_seen);
      $display("%0d unimplemented, %0d out of order; %0d field mismatches.",
               unimp_seen, order_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $error("timed out with %0d responses outstanding", pending_results.size());
      $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
design/rv32se_pkg.sv
design/rv32se_ram.sv
design/rv32se_regfile.sv
design/rv32se_exec.sv
design/rv32i_subset_execute_top.sv
bench/rv32i_subset_execute_top_test.sv
